/* sv/mbrp_pkg.sv */
`timescale 1ns / 1ps

package mbrp_pkg;

	localparam int unsigned POS_W       = 13;
	localparam int unsigned CFG_W       = 13;
	localparam int unsigned BYTES_W     = 44;
	localparam int unsigned LBA_W       = 32;

	localparam logic [POS_W-1:0] TABLE_FIRST = 13'd446;
	localparam logic [POS_W-1:0] SIG_FIRST   = 13'd510;
	localparam logic [POS_W-1:0] TABLE_LAST  = 13'd511;
	localparam logic [POS_W-1:0] POS_MAX     = 13'd8191;

	localparam logic [7:0] SIG_LO_BYTE = 8'h55;
	localparam logic [7:0] SIG_HI_BYTE = 8'hAA;
	localparam logic [7:0] GPT_TYPE    = 8'hEE;

	// offsets inside one 16-byte table entry
	localparam logic [3:0] ENT_TYPE_OFF = 4'd4;

	typedef enum logic [1:0] {
		ST_MBR_OK    = 2'd0,
		ST_GPT       = 2'd1,
		ST_BAD_SIG   = 2'd2,
		ST_SHORT     = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ENTRY  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_SCAN,
		BS_LEN,
		BS_EMIT
	} back_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       sector_end;
	} in_item_t;

	typedef struct packed {
		logic               record_kind;
		logic [1:0]         status;
		logic [1:0]         entry_index;
		logic [7:0]         part_type;
		logic [BYTES_W-1:0] start_bytes;
		logic [BYTES_W-1:0] length_bytes;
		logic               last_record;
	} out_item_t;

	// one parsed sector handed from front to back
	typedef struct packed {
		status_t              status;
		logic [3:0][7:0]      part_type;
		logic [3:0][3:0][7:0] lba;
		logic [3:0][3:0][7:0] cnt;
	} job_t;

endpackage

/* sv/mbrp_front.sv */
`timescale 1ns / 1ps

module mbrp_front
	import mbrp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     push,
	output job_t     job
);

	logic [POS_W-1:0]     pos_q;
	logic [3:0][7:0]      type_q;
	logic [3:0][3:0][7:0] lba_q;
	logic [3:0][3:0][7:0] cnt_q;
	logic [7:0]           sig_lo_q;
	logic [7:0]           sig_hi_q;

	logic             accept;
	logic             in_table;
	logic [POS_W-1:0] off_full;
	logic [6:0]       off;
	logic [1:0]       slot;
	logic [3:0]       sub;
	logic [7:0]       sig_hi_eff;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && in_data.sector_end;

	assign in_table = (pos_q >= TABLE_FIRST) && (pos_q <= TABLE_LAST);
	assign off_full = pos_q - TABLE_FIRST;
	assign off      = off_full[6:0];
	assign slot     = off[5:4];
	assign sub      = off[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (in_data.sector_end) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_table) begin
			if (!off[6]) begin
				if (sub == ENT_TYPE_OFF) begin
					type_q[slot] <= in_data.data_byte;
				end
				if (sub[3:2] == 2'b10) begin
					lba_q[slot][sub[1:0]] <= in_data.data_byte;
				end
				if (sub[3:2] == 2'b11) begin
					cnt_q[slot][sub[1:0]] <= in_data.data_byte;
				end
			end else if (!off[0]) begin
				sig_lo_q <= in_data.data_byte;
			end else begin
				sig_hi_q <= in_data.data_byte;
			end
		end
	end

	// last signature byte may be the one arriving now
	assign sig_hi_eff = (pos_q == TABLE_LAST) ? in_data.data_byte : sig_hi_q;

	always_comb begin
		job.part_type = type_q;
		job.lba       = lba_q;
		job.cnt       = cnt_q;
		if (pos_q < TABLE_LAST) begin
			job.status = ST_SHORT;
		end else if (sig_lo_q != SIG_LO_BYTE || sig_hi_eff != SIG_HI_BYTE) begin
			job.status = ST_BAD_SIG;
		end else if (type_q[0] == GPT_TYPE) begin
			job.status = ST_GPT;
		end else begin
			job.status = ST_MBR_OK;
		end
	end

endmodule

/* sv/mbrp_queue.sv */
`timescale 1ns / 1ps

module mbrp_queue
	import mbrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

endmodule

/* sv/mbrp_back.sv */
`timescale 1ns / 1ps

module mbrp_back
	import mbrp_pkg::*;
#(
	parameter int unsigned MAX_SECTOR_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  job_t             job,
	output logic             pop,
	input  logic [CFG_W-1:0] sector_bytes,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	localparam int unsigned SS_W   = $clog2(MAX_SECTOR_BYTES + 1);
	localparam int unsigned PROD_W = LBA_W + SS_W;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [1:0]         slot_q;
	logic               done_q;
	logic [BYTES_W-1:0] start_q;
	out_item_t          rec_q;

	logic [SS_W-1:0]   ss;
	logic [LBA_W-1:0]  mul_a;
	logic [PROD_W-1:0] prod;
	logic [7:0]        cur_type;
	logic              emit_status;
	logic              out_take;
	logic              advance;

	assign ss = (sector_bytes > CFG_W'(MAX_SECTOR_BYTES)) ? SS_W'(MAX_SECTOR_BYTES)
	                                                      : SS_W'(sector_bytes);
	// one multiplier shared between start and length
	assign mul_a    = (state_q == BS_LEN) ? job.cnt[slot_q] : job.lba[slot_q];
	assign prod     = PROD_W'(mul_a) * PROD_W'(ss);
	assign cur_type = job.part_type[slot_q];

	assign emit_status = (job.status != ST_MBR_OK) || done_q;
	assign out_valid   = (state_q == BS_EMIT);
	assign out_take    = out_valid && !out_stall;
	assign out_data    = rec_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (!q_empty) begin
					state_d = BS_SCAN;
				end
			end
			BS_SCAN: begin
				if (emit_status) begin
					state_d = BS_EMIT;
				end else if (cur_type != 8'd0) begin
					state_d = BS_LEN;
				end
			end
			BS_LEN: begin
				state_d = BS_EMIT;
			end
			BS_EMIT: begin
				if (out_take) begin
					state_d = rec_q.last_record ? BS_IDLE : BS_SCAN;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		advance = 1'b0;
		case (state_q)
			BS_SCAN: begin
				advance = !emit_status && (cur_type == 8'd0);
			end
			BS_EMIT: begin
				pop     = out_take && rec_q.last_record;
				advance = out_take && !rec_q.last_record;
			end
			default: begin
				pop     = 1'b0;
				advance = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			slot_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BS_IDLE) begin
				slot_q <= '0;
				done_q <= 1'b0;
			end else if (advance) begin
				if (slot_q == 2'd3) begin
					done_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BS_SCAN) begin
			start_q <= BYTES_W'(prod);
			if (emit_status) begin
				rec_q.record_kind  <= KIND_STATUS;
				rec_q.status       <= job.status;
				rec_q.entry_index  <= '0;
				rec_q.part_type    <= '0;
				rec_q.start_bytes  <= '0;
				rec_q.length_bytes <= '0;
				rec_q.last_record  <= 1'b1;
			end
		end
		if (state_q == BS_LEN) begin
			rec_q.record_kind  <= KIND_ENTRY;
			rec_q.status       <= ST_MBR_OK;
			rec_q.entry_index  <= slot_q;
			rec_q.part_type    <= cur_type;
			rec_q.start_bytes  <= start_q;
			rec_q.length_bytes <= BYTES_W'(prod);
			rec_q.last_record  <= 1'b0;
		end
	end

	a_entry_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.record_kind == KIND_ENTRY)
			|-> (job.status == ST_MBR_OK && !out_data.last_record))
		else $error("entry record for a sector that is not a plain mbr");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last_record) |-> (out_data.record_kind == KIND_STATUS))
		else $error("last record is not a status record");

	a_pop_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BS_IDLE))
		else $error("back end kept working after releasing its sector");

endmodule

/* sv/mbr_partition_table_parser.sv */
`timescale 1ns / 1ps

// mbr partition table parser
// in channel: one sector byte per request (in_data.data_byte), with
// in_data.sector_end on the last byte; accepted when in_valid and !in_stall.
// out channel: records in out_data, taken when out_valid and !out_stall.
// for a plain mbr one record per nonzero-type slot, then a status record
// with last_record set; otherwise only the status record.
// cfg channel: cfg_data sets bytes per sector; cfg_ready is always high.
// throughput: one byte per cycle. the front stores the table and hands each
// finished sector to a two-deep queue, so it stalls only while the queue
// holds two sectors, the one the back end works on and the next one.
// steps: with the back end idle, a finished sector is queued, the back end leaves
// idle for its scan state and a status-only result is registered for emit; an entry
// record passes scan and len (start and length share one 32 x 13 multiplier),
// an empty slot is skipped in scan, and the final status record passes scan and emit.
// while out_stall is high the current record holds on out_data.
// reset clears the byte position, the queue and the back-end state and sets
// the sector size to 512 bytes.
module mbr_partition_table_parser
	import mbrp_pkg::*;
#(
	parameter int unsigned MAX_SECTOR_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] sector_bytes_q;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	job_t             push_job;
	job_t             head_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_bytes_q <= CFG_W'(512);
		end else if (cfg_valid && cfg_ready) begin
			sector_bytes_q <= cfg_data;
		end
	end

	mbrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	mbrp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head_job)
	);

	mbrp_back #(
		.MAX_SECTOR_BYTES (MAX_SECTOR_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.job          (head_job),
		.pop          (pop),
		.sector_bytes (sector_bytes_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import mbrp_pkg::*;

	localparam int unsigned MAX_SECTOR       = 4096;
	localparam int unsigned CYCLE_LIMIT      = 1500000;
	localparam int unsigned DRAIN_LIMIT      = 20000;
	localparam int unsigned SETTLE_CYCLES    = 40;
	localparam int unsigned LONG_HOLD        = 3000;
	localparam int unsigned DIRECTED_SECTORS = 11;
	localparam int unsigned TABLE_BYTES      = 66;
	localparam int unsigned SIG_IDX          = SIG_FIRST - TABLE_FIRST;
	localparam int unsigned N_PHASES         = 8;

	typedef struct packed {
		logic     pause_first;
		in_item_t item;
	} queued_byte_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_pattern_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	queued_byte_t byte_q[$];
	out_item_t    expected_records[$];

	// shadow of the parser state
	logic [POS_W-1:0] byte_pos = '0;
	logic [7:0]       table_copy [TABLE_BYTES] = '{default: 8'h00};
	logic [CFG_W-1:0] sector_size = 13'd512;

	// table image of the next stimulus sector
	logic [7:0] sector_tbl [TABLE_BYTES] = '{default: 8'h00};

	int unsigned    cycle_count = 0;
	int unsigned    sectors_taken = 0;
	int unsigned    fail_count = 0;
	int unsigned    burst_left = 1;
	int unsigned    gap_left = 0;
	int unsigned    hold_left = 0;
	logic           long_hold_done = 1'b0;
	stall_pattern_t stall_mode = STALL_NONE;
	int unsigned    stall_mode_left = 0;

	mbr_partition_table_parser #(
		.MAX_SECTOR_BYTES(MAX_SECTOR)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void log_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	function automatic out_item_t status_record(status_t st);
		out_item_t r;
		r = '0;
		r.record_kind = KIND_STATUS;
		r.status = st;
		r.last_record = 1'b1;
		return r;
	endfunction

	function automatic void add_expected(out_item_t r);
		expected_records.insert(expected_records.size(), r);
	endfunction

	// advance the shadow parser by one sector byte, queue the records it yields
	task automatic predict_byte(input in_item_t it);
		logic [POS_W-1:0]   pos;
		logic [BYTES_W-1:0] scale;
		logic [LBA_W-1:0]   lba;
		logic [LBA_W-1:0]   cnt;
		out_item_t          r;
		int                 base;
		pos = byte_pos;
		if (pos >= TABLE_FIRST && pos <= TABLE_LAST)
			table_copy[pos - TABLE_FIRST] = it.data_byte;
		if (!it.sector_end) begin
			if (pos != POS_MAX)
				byte_pos = pos + 1'b1;
		end else begin
			byte_pos = '0;
			if (pos < TABLE_LAST) begin
				add_expected(status_record(ST_SHORT));
			end else if (table_copy[SIG_IDX] != SIG_LO_BYTE ||
					table_copy[SIG_IDX + 1] != SIG_HI_BYTE) begin
				add_expected(status_record(ST_BAD_SIG));
			end else if (table_copy[ENT_TYPE_OFF] == GPT_TYPE) begin
				add_expected(status_record(ST_GPT));
			end else begin
				// oversized sector sizes are clamped
				scale = (sector_size > MAX_SECTOR) ? BYTES_W'(MAX_SECTOR) : BYTES_W'(sector_size);
				for (int slot = 0; slot < 4; slot++) begin
					base = slot * 16;
					if (table_copy[base + ENT_TYPE_OFF] != 8'h00) begin
						lba = {table_copy[base + 11], table_copy[base + 10],
							table_copy[base + 9], table_copy[base + 8]};
						cnt = {table_copy[base + 15], table_copy[base + 14],
							table_copy[base + 13], table_copy[base + 12]};
						r = '0;
						r.record_kind = KIND_ENTRY;
						r.entry_index = 2'(slot);
						r.part_type = table_copy[base + ENT_TYPE_OFF];
						r.start_bytes = BYTES_W'(lba) * scale;
						r.length_bytes = BYTES_W'(cnt) * scale;
						add_expected(r);
					end
				end
				add_expected(status_record(ST_MBR_OK));
			end
		end
	endtask

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic set_entry(input int slot, input logic [7:0] ptype,
			input logic [31:0] lba, input logic [31:0] cnt);
		for (int k = 0; k < 16; k++)
			sector_tbl[slot * 16 + k] = 8'($urandom);
		sector_tbl[slot * 16 + ENT_TYPE_OFF] = ptype;
		for (int k = 0; k < 4; k++) begin
			sector_tbl[slot * 16 + 8 + k] = lba[8 * k +: 8];
			sector_tbl[slot * 16 + 12 + k] = cnt[8 * k +: 8];
		end
	endtask

	task automatic set_sig(input logic [7:0] lo, input logic [7:0] hi);
		sector_tbl[SIG_IDX] = lo;
		sector_tbl[SIG_IDX + 1] = hi;
	endtask

	task automatic fill_random_table();
		logic [7:0] ptype;
		for (int s = 0; s < 4; s++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: ptype = 8'h00;
				3: ptype = GPT_TYPE;
				default: ptype = 8'($urandom);
			endcase
			set_entry(s, ptype, pick_count(), pick_count());
		end
		if ($urandom_range(0, 9) < 8)
			set_sig(SIG_LO_BYTE, SIG_HI_BYTE);
		else
			set_sig(8'($urandom), 8'($urandom));
	endtask

	// queue one sector: random filler around the current table image
	task automatic push_sector(input int len, input bit pause_first);
		queued_byte_t qb;
		for (int p = 0; p < len; p++) begin
			qb.pause_first = pause_first && (p == 0);
			qb.item.data_byte = (p >= TABLE_FIRST && p <= TABLE_LAST) ?
				sector_tbl[p - TABLE_FIRST] : 8'($urandom);
			qb.item.sector_end = (p == len - 1);
			byte_q.insert(byte_q.size(), qb);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		queued_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			sectors_taken <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(in_data);
				if (in_data.sector_end)
					sectors_taken <= sectors_taken + 1;
			end
			// a stalled request keeps its payload
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (byte_q.size() == 0 ||
						(byte_q[0].pause_first && expected_records.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					nxt = byte_q.pop_front();
					in_valid <= 1'b1;
					in_data <= nxt.item;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 600 : $urandom_range(1, 64);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// output stall pattern, with one long hold once the directed sectors are in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (!long_hold_done && sectors_taken == DIRECTED_SECTORS) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (stall_mode_left == 0) begin
					stall_mode = stall_pattern_t'($urandom_range(0, 3));
					stall_mode_left = $urandom_range(20, 200);
				end else
					stall_mode_left--;
				case (stall_mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((cycle_count % 5) < 2);
				endcase
			end
		end
	end

	// record checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_records.size() == 0) begin
				log_failure($sformatf("unexpected record %h", out_data));
			end else begin
				want = expected_records.pop_front();
				if (out_data.record_kind !== want.record_kind ||
						out_data.status !== want.status ||
						out_data.entry_index !== want.entry_index ||
						out_data.part_type !== want.part_type ||
						out_data.start_bytes !== want.start_bytes ||
						out_data.length_bytes !== want.length_bytes ||
						out_data.last_record !== want.last_record)
					log_failure($sformatf({"kind %0d status %0d slot %0d type %h start %h len %h ",
						"last %0d, expected kind %0d status %0d slot %0d type %h start %h ",
						"len %h last %0d"},
						out_data.record_kind, out_data.status, out_data.entry_index,
						out_data.part_type, out_data.start_bytes, out_data.length_bytes,
						out_data.last_record, want.record_kind, want.status,
						want.entry_index, want.part_type, want.start_bytes,
						want.length_bytes, want.last_record));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] cfg_plan [N_PHASES];
		int               len;
		int unsigned      waited;
		cfg_plan = '{13'd512, 13'd4096, 13'd8191, 13'd0, 13'd1, 13'd4097,
			13'($urandom_range(512, 4096)), 13'($urandom)};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			@(posedge clk);
			cfg_valid <= 1'b1;
			cfg_data <= cfg_plan[ph];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sector_size = cfg_plan[ph];
			cfg_valid <= 1'b0;
			if (ph == 0) begin
				// one-byte sector, then one that ends a byte short of the signature end
				fill_random_table();
				push_sector(1, 1'b0);
				push_sector(511, 1'b0);
				// every slot used, extreme lba and count values
				set_entry(0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				set_entry(1, 8'h01, 32'h0000_0000, 32'h0000_0001);
				set_entry(2, 8'h80, 32'h8000_0000, 32'h0000_0000);
				set_entry(3, 8'h7F, 32'h0000_0001, 32'h7FFF_FFFF);
				set_sig(SIG_LO_BYTE, SIG_HI_BYTE);
				push_sector(512, 1'b1);
				for (int s = 0; s < 4; s++)
					set_entry(s, 8'h00, pick_count(), pick_count());
				push_sector(512, 1'b0);
				set_entry(0, GPT_TYPE, 32'h0000_0001, 32'hFFFF_FFFF);
				push_sector(512, 1'b0);
				// protective type outside slot 0 is an ordinary entry
				set_entry(0, 8'h00, pick_count(), pick_count());
				set_entry(2, GPT_TYPE, pick_count(), pick_count());
				push_sector(512, 1'b0);
				set_sig(SIG_LO_BYTE, 8'h00);
				push_sector(512, 1'b0);
				set_sig(8'h00, SIG_HI_BYTE);
				push_sector(512, 1'b0);
				set_sig(SIG_HI_BYTE, SIG_LO_BYTE);
				push_sector(512, 1'b0);
				// trailing bytes ignored; the longest one saturates the position
				fill_random_table();
				set_sig(SIG_LO_BYTE, SIG_HI_BYTE);
				push_sector(600, 1'b1);
				fill_random_table();
				set_sig(SIG_LO_BYTE, SIG_HI_BYTE);
				push_sector(8300, 1'b1);
				// short sectors pile up behind the long output hold
				repeat (8) begin
					fill_random_table();
					push_sector($urandom_range(1, 40), 1'b0);
				end
			end
			repeat (6) begin
				fill_random_table();
				case ($urandom_range(0, 19))
					0, 1: len = $urandom_range(1, 511);
					2, 3: len = $urandom_range(513, 1024);
					default: len = 512;
				endcase
				push_sector(len, $urandom_range(0, 7) == 0);
			end
			while (byte_q.size() != 0 || in_valid)
				@(posedge clk);
			waited = 0;
			while (expected_records.size() != 0 && waited < DRAIN_LIMIT) begin
				@(posedge clk);
				waited++;
			end
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (expected_records.size() != 0) begin
				log_failure($sformatf("%0d records never arrived", expected_records.size()));
				expected_records.delete();
			end
		end
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* mbr_partition_table_parser.f */
sv/mbrp_pkg.sv
sv/mbrp_front.sv
sv/mbrp_queue.sv
sv/mbrp_back.sv
sv/mbr_partition_table_parser.sv
bench/tb.sv
